### rtl/kalman_angle_gyro_fusion_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle/gyro fusion block
// Shared immediate-style wrappers around concurrent implication checks.
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_GYRO_FUSION_TOP_MACROS_SVH
`define KALMAN_ANGLE_GYRO_FUSION_TOP_MACROS_SVH

// same-cycle implication
`define KAGF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KAGF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/kagf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kagf_pkg
// Types, codes and saturation helpers for the angle/gyro fusion filter.
// ----------------------------------------------------------------------------
package kagf_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_NOISE   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_NOISE    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_NOISE = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_TIME     = 8'd3;

   localparam logic [47:0] ANGLE_NOISE_RST   = 48'd1099512;
   localparam logic [47:0] BIAS_NOISE_RST    = 48'd109951163;
   localparam logic [47:0] MEASURE_NOISE_RST = 48'd549755813888;
   localparam logic [31:0] STEP_TIME_RST     = 32'd8589935;
   localparam logic [47:0] ONE_Q40           = 48'h0100_0000_0000;

   typedef logic [3:0] op_type;

   // sequence order of the filter step
   localparam op_type OP_PRED_ANGLE = 4'd0;
   localparam op_type OP_PRED_AA    = 4'd1;
   localparam op_type OP_PRED_CROSS = 4'd2;
   localparam op_type OP_PRED_BB    = 4'd3;
   localparam op_type OP_GAIN_ANGLE = 4'd4;
   localparam op_type OP_GAIN_BIAS  = 4'd5;
   localparam op_type OP_CORR_BA    = 4'd6;
   localparam op_type OP_CORR_BB    = 4'd7;
   localparam op_type OP_CORR_AA    = 4'd8;
   localparam op_type OP_CORR_AB    = 4'd9;
   localparam op_type OP_UPD_ANGLE  = 4'd10;
   localparam op_type OP_UPD_BIAS   = 4'd11;

   typedef struct packed {
      logic   load_in;
      logic   start_mul;
      logic   start_div;
      logic   write;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v[65:31] == {35{v[65]}}) return v[31:0];
      return v[65] ? 32'h8000_0000 : 32'h7fff_ffff;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
      if (v[65:47] == {19{v[65]}}) return v[47:0];
      return v[65] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
   endfunction

endpackage

### rtl/kagf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kagf_if
// Request, response and register-write channels of the fusion filter.
// ----------------------------------------------------------------------------
interface kagf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_angle;
   logic signed [31:0] gyro_rate;
   modport source (output valid, accel_angle, gyro_rate, input ready);
   modport sink   (input valid, accel_angle, gyro_rate, output ready);
endinterface

interface kagf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] fused_angle;
   logic signed [31:0] fused_rate;
   modport source (output valid, fused_angle, fused_rate, input ready);
   modport sink   (input valid, fused_angle, fused_rate, output ready);
endinterface

interface kagf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kagf_pkg::CSR_INDEX_W-1:0]    index;
   logic [kagf_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/kagf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kagf_mul
// Sequenced signed multiplier: four 32x32 partial products, floor shift.
// ----------------------------------------------------------------------------
module kagf_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   input  logic               shift40,
   output logic               done,
   output logic signed [63:0] result
);

   logic        busy_ff, busy_in;
   logic [2:0]  idx_ff, idx_in;
   logic        done_ff, done_in;
   logic [63:0] ma_ff, mb_ff;
   logic        neg_ff, s40_ff;
   logic [63:0] pp_ff;
   logic [1:0]  ppsh_ff;
   logic [127:0] acc_ff;
   logic signed [63:0] res_ff;

   logic [31:0]  ha, hb;
   logic [96:0]  q, qm;
   logic         rem;

   assign ha = idx_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign hb = idx_ff[1] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      q   = s40_ff ? {9'd0, acc_ff[127:40]} : {1'b0, acc_ff[127:32]};
      rem = s40_ff ? (|acc_ff[39:0]) : (|acc_ff[31:0]);
      qm  = q + {96'd0, neg_ff & rem};
      if (qm > (97'd1 << 62)) qm = 97'd1 << 62;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (busy_ff) begin
         idx_in = idx_ff + 3'd1;
         if (idx_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= a[63] ? 64'(-a) : 64'(a);
         mb_ff  <= b[63] ? 64'(-b) : 64'(b);
         neg_ff <= a[63] ^ b[63];
         s40_ff <= shift40;
         acc_ff <= 128'd0;
      end else if (busy_ff) begin
         if (idx_ff < 3'd4) begin
            pp_ff   <= 64'(ha) * 64'(hb);
            ppsh_ff <= 2'({1'b0, idx_ff[0]} + {1'b0, idx_ff[1]});
         end
         if (idx_ff >= 3'd1 && idx_ff <= 3'd4)
            acc_ff <= acc_ff + ({64'd0, pp_ff} << {ppsh_ff, 5'd0});
         if (idx_ff == 3'd5)
            res_ff <= neg_ff ? -$signed(qm[63:0]) : $signed(qm[63:0]);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### rtl/kagf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kagf_div
// Restoring divider for the gains: (num * 2^40) / den, one bit per cycle.
// ----------------------------------------------------------------------------
module kagf_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] num,
   input  logic [48:0]        den,
   output logic               done,
   output logic signed [47:0] quot
);

   localparam logic [6:0] STEPS = 7'd88;

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [47:0] n_ff;
   logic [48:0] d_ff, r_ff, r_in;
   logic [50:0] q_ff, q_in, qc;
   logic        over_ff, over_in, neg_ff, ge;
   logic [49:0] r2;
   logic signed [47:0] quot_ff;

   always_comb begin
      r2      = {r_ff, n_ff[47]};
      ge      = r2 >= {1'b0, d_ff};
      r_in    = ge ? 49'(r2 - {1'b0, d_ff}) : r2[48:0];
      q_in    = {q_ff[49:0], ge};
      over_in = over_ff | q_ff[50];
      qc      = (over_in || q_in > (51'd1 << 47)) ? (51'd1 << 47) : q_in;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEPS;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= num[47] ? 48'(-num) : 48'(num);
         neg_ff  <= num[47];
         d_ff    <= den;
         r_ff    <= 49'd0;
         q_ff    <= 51'd0;
         over_ff <= 1'b0;
      end else if (busy_ff) begin
         n_ff    <= {n_ff[46:0], 1'b0};
         r_ff    <= r_in;
         q_ff    <= q_in;
         over_ff <= over_in;
         if (cnt_ff == 7'd1) begin
            // a positive quotient at the 2^47 cap saturates to the top code
            if (neg_ff)
               quot_ff <= -$signed(qc[47:0]);
            else if (qc[47])
               quot_ff <= 48'h7fff_ffff_ffff;
            else
               quot_ff <= $signed(qc[47:0]);
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### rtl/kagf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kagf_dpath
// Filter state, registers and the shared multiplier and divider.
// ----------------------------------------------------------------------------
module kagf_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  kagf_pkg::cmd_type                cmd,
   output kagf_pkg::stat_type               status,
   input  logic                             csr_we,
   input  logic [kagf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kagf_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic signed [31:0]               accel_angle,
   input  logic signed [31:0]               gyro_rate,
   output logic signed [31:0]               fused_angle,
   output logic signed [31:0]               fused_rate
);

   logic [47:0] angle_noise_ff, bias_noise_ff, measure_noise_ff;
   logic [31:0] step_time_ff;
   logic signed [31:0] angle_ff, bias_ff, accel_ff, gyro_ff;
   logic signed [47:0] aa_ff, ab_ff, ba_ff, bb_ff, k0_ff, k1_ff;
   logic signed [32:0] err_ff;
   logic signed [31:0] fused_angle_ff, fused_rate_ff;

   logic signed [63:0] mul_a, mul_b, mul_res;
   logic               mul_s40;
   logic signed [47:0] div_num, div_quot;
   logic signed [49:0] e_sum;
   logic [48:0]        div_den;

   function automatic logic signed [63:0] x48(input logic signed [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

   function automatic logic signed [65:0] w48(input logic signed [47:0] v);
      return {{18{v[47]}}, v};
   endfunction

   function automatic logic signed [65:0] w32(input logic signed [31:0] v);
      return {{34{v[31]}}, v};
   endfunction

   function automatic logic signed [65:0] w64(input logic signed [63:0] v);
      return {{2{v[63]}}, v};
   endfunction

   always_comb begin
      mul_a   = 64'sd0;
      mul_b   = 64'sd0;
      mul_s40 = 1'b1;
      unique case (cmd.op)
         kagf_pkg::OP_PRED_ANGLE: mul_a = {{32{gyro_ff[31]}}, gyro_ff}
                                        - {{32{bias_ff[31]}}, bias_ff};
         kagf_pkg::OP_PRED_AA:    mul_a = $signed({16'd0, angle_noise_ff})
                                        - x48(ab_ff) - x48(ba_ff);
         kagf_pkg::OP_PRED_CROSS: mul_a = -x48(bb_ff);
         kagf_pkg::OP_PRED_BB:    mul_a = $signed({16'd0, bias_noise_ff});
         kagf_pkg::OP_CORR_BA:    begin mul_a = x48(k1_ff); mul_b = x48(aa_ff); end
         kagf_pkg::OP_CORR_BB:    begin mul_a = x48(k1_ff); mul_b = x48(ab_ff); end
         kagf_pkg::OP_CORR_AA:    begin mul_a = x48(k0_ff); mul_b = x48(aa_ff); end
         kagf_pkg::OP_CORR_AB:    begin mul_a = x48(k0_ff); mul_b = x48(ab_ff); end
         kagf_pkg::OP_UPD_ANGLE:  begin
            mul_a = x48(k0_ff);
            mul_b = {{31{err_ff[32]}}, err_ff};
         end
         kagf_pkg::OP_UPD_BIAS:   begin
            mul_a = x48(k1_ff);
            mul_b = {{31{err_ff[32]}}, err_ff};
         end
         default: ;
      endcase
      // prediction steps scale by the Q0.32 step time
      if (cmd.op inside {kagf_pkg::OP_PRED_ANGLE, kagf_pkg::OP_PRED_AA,
                         kagf_pkg::OP_PRED_CROSS, kagf_pkg::OP_PRED_BB}) begin
         mul_b   = $signed({32'd0, step_time_ff});
         mul_s40 = 1'b0;
      end
   end

   always_comb begin
      div_num = (cmd.op == kagf_pkg::OP_GAIN_ANGLE) ? aa_ff : ba_ff;
      e_sum   = $signed({2'b00, measure_noise_ff}) + $signed({{2{aa_ff[47]}}, aa_ff});
      // clamp a non-positive innovation variance to one LSB
      div_den = (e_sum[49] || e_sum == 50'sd0) ? 49'd1 : e_sum[48:0];
   end

   kagf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.start_mul),
      .a       (mul_a),
      .b       (mul_b),
      .shift40 (mul_s40),
      .done    (status.mul_done),
      .result  (mul_res)
   );

   kagf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .num   (div_num),
      .den   (div_den),
      .done  (status.div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_noise_ff   <= kagf_pkg::ANGLE_NOISE_RST;
         bias_noise_ff    <= kagf_pkg::BIAS_NOISE_RST;
         measure_noise_ff <= kagf_pkg::MEASURE_NOISE_RST;
         step_time_ff     <= kagf_pkg::STEP_TIME_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            kagf_pkg::CSR_ANGLE_NOISE:   angle_noise_ff   <= csr_data;
            kagf_pkg::CSR_BIAS_NOISE:    bias_noise_ff    <= csr_data;
            kagf_pkg::CSR_MEASURE_NOISE: measure_noise_ff <= csr_data;
            kagf_pkg::CSR_STEP_TIME:     step_time_ff     <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= 32'sd0;
         bias_ff  <= 32'sd0;
         aa_ff    <= kagf_pkg::ONE_Q40;
         ab_ff    <= 48'sd0;
         ba_ff    <= 48'sd0;
         bb_ff    <= kagf_pkg::ONE_Q40;
      end else if (cmd.write) begin
         unique case (cmd.op)
            kagf_pkg::OP_PRED_ANGLE: angle_ff <= kagf_pkg::sat32(w32(angle_ff) + w64(mul_res));
            kagf_pkg::OP_PRED_AA:    aa_ff <= kagf_pkg::sat48(w48(aa_ff) + w64(mul_res));
            kagf_pkg::OP_PRED_CROSS: begin
               ab_ff <= kagf_pkg::sat48(w48(ab_ff) + w64(mul_res));
               ba_ff <= kagf_pkg::sat48(w48(ba_ff) + w64(mul_res));
            end
            kagf_pkg::OP_PRED_BB:    bb_ff <= kagf_pkg::sat48(w48(bb_ff) + w64(mul_res));
            kagf_pkg::OP_CORR_BA:    ba_ff <= kagf_pkg::sat48(w48(ba_ff) - w64(mul_res));
            kagf_pkg::OP_CORR_BB:    bb_ff <= kagf_pkg::sat48(w48(bb_ff) - w64(mul_res));
            kagf_pkg::OP_CORR_AA:    aa_ff <= kagf_pkg::sat48(w48(aa_ff) - w64(mul_res));
            kagf_pkg::OP_CORR_AB:    ab_ff <= kagf_pkg::sat48(w48(ab_ff) - w64(mul_res));
            kagf_pkg::OP_UPD_ANGLE:  angle_ff <= kagf_pkg::sat32(w32(angle_ff) + w64(mul_res));
            kagf_pkg::OP_UPD_BIAS:   bias_ff <= kagf_pkg::sat32(w32(bias_ff) + w64(mul_res));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         accel_ff <= accel_angle;
         gyro_ff  <= gyro_rate;
      end
      if (cmd.write) begin
         unique case (cmd.op)
            // predicted angle is final once the bias variance is written
            kagf_pkg::OP_PRED_BB:    err_ff <= {accel_ff[31], accel_ff} - {angle_ff[31], angle_ff};
            kagf_pkg::OP_GAIN_ANGLE: k0_ff <= div_quot;
            kagf_pkg::OP_GAIN_BIAS:  k1_ff <= div_quot;
            default: ;
         endcase
      end
      if (cmd.emit) begin
         fused_angle_ff <= angle_ff;
         fused_rate_ff  <= kagf_pkg::sat32(w32(gyro_ff) - w32(bias_ff));
      end
   end

   assign fused_angle = fused_angle_ff;
   assign fused_rate  = fused_rate_ff;

endmodule

### rtl/kagf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kagf_ctrl
// Sequencer of the filter step: issues each operation and holds the result.
// ----------------------------------------------------------------------------
`include "kalman_angle_gyro_fusion_top_macros.svh"
module kagf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output kagf_pkg::cmd_type   cmd,
   input  kagf_pkg::stat_type  status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   kagf_pkg::op_type op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             is_div, unit_done;

   assign is_div    = (op_ff == kagf_pkg::OP_GAIN_ANGLE) || (op_ff == kagf_pkg::OP_GAIN_BIAS);
   assign unit_done = is_div ? status.div_done : status.mul_done;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = op_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               op_in       = kagf_pkg::OP_PRED_ANGLE;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start_mul = !is_div;
            cmd.start_div = is_div;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               cmd.write = 1'b1;
               if (op_ff == kagf_pkg::OP_UPD_BIAS) begin
                  state_in = ST_EMIT;
               end else begin
                  op_in    = op_ff + 4'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= kagf_pkg::OP_PRED_ANGLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `KAGF_ASSERT_NEXT(a_start_wait, clock, reset, cmd.start_mul || cmd.start_div, state_ff == ST_WAIT, "unit started outside the issue step")
   `KAGF_ASSERT_NOW(a_mul_done_wait, clock, reset, status.mul_done, state_ff == ST_WAIT && !is_div, "multiplier finished while not awaited")
   `KAGF_ASSERT_NOW(a_div_done_wait, clock, reset, status.div_done, state_ff == ST_WAIT && is_div, "divider finished while not awaited")
   `KAGF_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff && state_ff == ST_IDLE, "emitted result not presented")

endmodule

### rtl/kalman_angle_gyro_fusion_top.sv
`timescale 1ns / 1ps
// A request is taken only while idle, after the previous step has been emitted; each step
// runs ten multiplies on the shared 32x32 partial-product multiplier and two gain divisions.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) restores the filter state and register defaults.
// ----------------------------------------------------------------------------
// kalman_angle_gyro_fusion_top
// Two-state angle/gyro-bias Kalman filter with a register write port.
// ----------------------------------------------------------------------------
module kalman_angle_gyro_fusion_top (
   input  logic       clock,
   input  logic       reset,
   kagf_req_if.sink   req_ch,
   kagf_rsp_if.source rsp_ch,
   kagf_csr_if.sink   csr_ch
);

   kagf_pkg::cmd_type  cmd;
   kagf_pkg::stat_type status;

   assign csr_ch.ready = 1'b1;

   kagf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   kagf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_ch.valid),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .accel_angle (req_ch.accel_angle),
      .gyro_rate   (req_ch.gyro_rate),
      .fused_angle (rsp_ch.fused_angle),
      .fused_rate  (rsp_ch.fused_rate)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the angle/gyro fusion filter. A bit-true model of
// the filter step predicts each fused sample. Responses are checked in order,
// with random gaps, back-pressure and register settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int  SETTLE_CYCLES = 300;
   localparam int  WATCHDOG_LIMIT = 20000;
   localparam longint MAX48 = 64'sd140737488355327;
   localparam longint MIN48 = -64'sd140737488355328;
   localparam longint UNIT_Q40 = 64'sd1099511627776;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
   } fused_sample_type;

   logic clock = 1'b0;
   logic reset;

   kagf_req_if req_bus ();
   kagf_rsp_if rsp_bus ();
   kagf_csr_if csr_bus ();

   kalman_angle_gyro_fusion_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state and register copies
   longint angle_noise_q, bias_noise_q, measure_noise_q, step_time_q;
   longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;

   fused_sample_type fused_due[$];
   int  errors = 0;
   bit  gaps_on = 1'b1;
   int  rsp_hold = 0;
   int  quiet_cycles = 0;

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip48(input longint v);
      if (v > MAX48) return MAX48;
      if (v < MIN48) return MIN48;
      return v;
   endfunction

   // floor(a*b / 2^s) with magnitude capped at 2^62
   function automatic longint mul_shift(input longint a, input longint b, input int s);
      bit          neg;
      logic [127:0] ma, mb, prod, quo;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? 128'(-a) : 128'(a);
      mb   = (b < 0) ? 128'(-b) : 128'(b);
      prod = ma * mb;
      quo  = prod >> s;
      if (neg && ((prod & ((128'd1 << s) - 1)) != 0)) quo = quo + 1;
      if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
      return neg ? -longint'(quo) : longint'(quo);
   endfunction

   // gain = num * 2^40 / den, truncated toward zero, clipped to 48 bits
   function automatic longint gain_div(input longint num, input longint den);
      bit          neg;
      logic [127:0] mag, quo;
      neg = num < 0;
      mag = (neg ? 128'(-num) : 128'(num)) & ((128'd1 << 48) - 1);
      quo = (mag << 40) / 128'(den);
      if (quo > (128'd1 << 47)) quo = 128'd1 << 47;
      return clip48(neg ? -longint'(quo) : longint'(quo));
   endfunction

   function automatic fused_sample_type fuse_step(input longint accel, input longint gyro);
      fused_sample_type r;
      longint err, den, k0, k1, old_bb, old_aa, old_ab;
      angle_est = clip32(angle_est + mul_shift(gyro - bias_est, step_time_q, 32));
      old_bb = p_bb;
      p_aa = clip48(p_aa + mul_shift(angle_noise_q - p_ab - p_ba, step_time_q, 32));
      p_ab = clip48(p_ab + mul_shift(-old_bb, step_time_q, 32));
      p_ba = clip48(p_ba + mul_shift(-old_bb, step_time_q, 32));
      p_bb = clip48(p_bb + mul_shift(bias_noise_q, step_time_q, 32));
      err = accel - angle_est;
      den = measure_noise_q + p_aa;
      if (den < 1) den = 1;
      k0 = gain_div(p_aa, den);
      k1 = gain_div(p_ba, den);
      old_aa = p_aa;
      old_ab = p_ab;
      p_aa = clip48(old_aa - mul_shift(k0, old_aa, 40));
      p_ab = clip48(old_ab - mul_shift(k0, old_ab, 40));
      p_ba = clip48(p_ba - mul_shift(k1, old_aa, 40));
      p_bb = clip48(p_bb - mul_shift(k1, old_ab, 40));
      angle_est = clip32(angle_est + mul_shift(k0, err, 40));
      bias_est = clip32(bias_est + mul_shift(k1, err, 40));
      r.angle = 32'(angle_est);
      r.rate = 32'(clip32(gyro - bias_est));
      return r;
   endfunction

   // response side: back-pressure and in-order check
   always @(posedge clock) begin
      fused_sample_type exp_s;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (fused_due.size() == 0) begin
               $display("%0t: unexpected response angle=%0d rate=%0d", $time,
                        rsp_bus.fused_angle, rsp_bus.fused_rate);
               errors++;
            end else begin
               exp_s = fused_due.pop_front();
               if (rsp_bus.fused_angle !== exp_s.angle) begin
                  $display("%0t: fused_angle expected %0d actual %0d", $time,
                           exp_s.angle, rsp_bus.fused_angle);
                  errors++;
               end
               if (rsp_bus.fused_rate !== exp_s.rate) begin
                  $display("%0t: fused_rate expected %0d actual %0d", $time,
                           exp_s.rate, rsp_bus.fused_rate);
                  errors++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(gaps_on && $urandom_range(99) < 22);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [31:0] accel, input logic signed [31:0] gyro);
      if (gaps_on && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while (gaps_on && $urandom_range(99) < 22) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.accel_angle <= accel;
      req_bus.gyro_rate <= gyro;
      do @(posedge clock); while (!req_bus.ready);
      fused_due.push_back(fuse_step(longint'(accel), longint'(gyro)));
   endtask

   // lower valid, wait out every pending response, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (fused_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [kagf_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [47:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         kagf_pkg::CSR_ANGLE_NOISE:   angle_noise_q = longint'(value);
         kagf_pkg::CSR_BIAS_NOISE:    bias_noise_q = longint'(value);
         kagf_pkg::CSR_MEASURE_NOISE: measure_noise_q = longint'(value);
         kagf_pkg::CSR_STEP_TIME:     step_time_q = longint'(value[31:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [47:0] qa, input logic [47:0] qb,
                            input logic [47:0] rm, input logic [31:0] dt);
      write_reg(kagf_pkg::CSR_ANGLE_NOISE, qa);
      write_reg(kagf_pkg::CSR_BIAS_NOISE, qb);
      write_reg(kagf_pkg::CSR_MEASURE_NOISE, rm);
      write_reg(kagf_pkg::CSR_STEP_TIME, {16'd0, dt});
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // near-level tilt and slow rates keep the filter in its working region
   function automatic logic signed [31:0] small_q16(input int span);
      return 32'($signed($urandom_range(2 * span)) - span);
   endfunction

   task automatic test_field_extremes();
      send_sample(32'sd0, 32'sd0);
      send_sample(32'sh7fff_ffff, 32'sh7fff_ffff);
      send_sample(32'sh8000_0000, 32'sh8000_0000);
      send_sample(32'sh7fff_ffff, 32'sh8000_0000);
      send_sample(32'sh8000_0000, 32'sh7fff_ffff);
      send_sample(-32'sd1, 32'sd1);
      send_sample(32'sh0001_0000, -32'sh0001_0000);
      send_sample(32'h5555_5555, 32'haaaa_aaaa);
      drain();
   endtask

   task automatic test_register_extremes();
      // shortest step and smallest measurement noise: gains near one
      write_all(48'd0, 48'd0, 48'd1, 32'd1);
      send_sample(32'sh0010_0000, 32'sh0002_0000);
      send_sample(-32'sh0010_0000, 32'sd0);
      send_sample(32'sh7fff_ffff, 32'sh8000_0000);
      drain();
      // longest step with full noise: covariance overflows and saturates
      write_all(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff);
      send_sample(32'sh8000_0000, 32'sh7fff_ffff);
      send_sample(32'sh7fff_ffff, 32'sh7fff_ffff);
      send_sample(32'sd0, 32'sh8000_0000);
      send_sample(32'sh0000_8000, -32'sd1);
      drain();
      // tiny measurement noise after negative drift: denominator may go non-positive
      write_all(48'hffff_ffff_ffff, 48'd0, 48'd1, 32'hffff_ffff);
      send_sample(32'sh8000_0000, 32'sh8000_0000);
      send_sample(32'sh7fff_ffff, 32'sd0);
      drain();
      write_all(kagf_pkg::ANGLE_NOISE_RST, kagf_pkg::BIAS_NOISE_RST,
                kagf_pkg::MEASURE_NOISE_RST, kagf_pkg::STEP_TIME_RST);
   endtask

   task automatic test_random_phases();
      logic [47:0] rm;
      logic [31:0] dt;
      for (int ph = 0; ph < 12; ph++) begin
         if (ph % 3 == 2) begin
            rm = rand48();
            dt = $urandom;
            if (rm == 0) rm = 48'd1;
            if (dt == 0) dt = 32'd1;
            write_all(rand48(), rand48(), rm, dt);
         end else begin
            write_all(48'($urandom_range(1 << 24)), 48'($urandom_range(1 << 30)),
                      48'($urandom_range(1, 32'hffff_ffff)) << 8,
                      32'($urandom_range(1, 1 << 27)));
         end
         gaps_on = (ph != 4);
         for (int n = 0; n < 130; n++) begin
            if ($urandom_range(9) < 8)
               send_sample(small_q16(90 << 16), small_q16(500 << 16));
            else
               send_sample($urandom, $urandom);
         end
         drain();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      rsp_hold <= 1500;
      for (int n = 0; n < 20; n++) send_sample(small_q16(45 << 16), small_q16(100 << 16));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.accel_angle <= '0;
      req_bus.gyro_rate <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      angle_noise_q = longint'(kagf_pkg::ANGLE_NOISE_RST);
      bias_noise_q = longint'(kagf_pkg::BIAS_NOISE_RST);
      measure_noise_q = longint'(kagf_pkg::MEASURE_NOISE_RST);
      step_time_q = longint'(kagf_pkg::STEP_TIME_RST);
      angle_est = 0;
      bias_est = 0;
      p_aa = UNIT_Q40;
      p_ab = 0;
      p_ba = 0;
      p_bb = UNIT_Q40;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_register_extremes();
      test_backpressure();
      test_random_phases();
      test_backpressure();

      if (errors == 0 && fused_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
